@@ sv/soft_power_switch_controller_core_assert.svh @@
// Assertion macros used by the checker file of the soft power switch core.
`ifndef SOFT_POWER_SWITCH_CONTROLLER_CORE_ASSERT_SVH
`define SOFT_POWER_SWITCH_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SPSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spsc assertion failed");

// Next-cycle implication, disabled in reset.
`define SPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spsc assertion failed");

`endif

@@ sv/spsc_pkg.sv @@
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared types and constants of the soft power switch controller.
// ----------------------------------------------------------------------------
package spsc_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int HoldW    = 16;
    localparam int SettleW  = 8;

    typedef enum logic [CfgIdxW-1:0] {
        CfgAtxMode        = 3'd0,
        CfgRestoreEnable  = 3'd1,
        CfgPowerdownTicks = 3'd2,
        CfgTurboTicks     = 3'd3,
        CfgOnSettleTicks  = 3'd4,
        CfgOffSettleTicks = 3'd5
    } cfg_idx_t;

    localparam logic             RstAtxMode        = 1'b1;
    localparam logic             RstRestoreEnable  = 1'b1;
    localparam logic [HoldW-1:0] RstPowerdownTicks = 16'd500;
    localparam logic [HoldW-1:0] RstTurboTicks     = 16'd100;
    localparam logic [SettleW-1:0] RstOnSettle     = 8'd10;
    localparam logic [SettleW-1:0] RstOffSettle    = 8'd1;

    // Hold counter wraps to zero when it reaches this value
    localparam logic [HoldW-1:0] HoldWrap = 16'd65530;

endpackage

@@ sv/soft_power_switch_controller_core.sv @@
// ----------------------------------------------------------------------------
// soft_power_switch_controller_core
// Soft power-button controller: tick and restore transactions in, one
// result transaction (power, turbo, persist flags) out for each.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_stall   cmd button_pressed saved_*
//  result    out        result_valid / result_stall supply_on turbo_on persist_*
//  cfg       in         cfg_valid / cfg_ready     cfg_index cfg_data
//
//  One transaction per cycle while item_stall is low; its result is registered.
//  The state update and result come from one pass of logic on the state regs.
//  A two-entry output (result register plus skid) absorbs one result stall;
//  item_stall rises only while the skid entry is full.
//  Reset (rst_n low, async) clears state, config to defaults, no valid result.
// ----------------------------------------------------------------------------
module soft_power_switch_controller_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic                          cmd,
    input  logic                          button_pressed,
    input  logic                          saved_power,
    input  logic                          saved_turbo,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          supply_on,
    output logic                          turbo_on,
    output logic                          persist_power,
    output logic                          persist_turbo,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spsc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [spsc_pkg::CfgDataW-1:0] cfg_data
);
    import spsc_pkg::*;

    typedef enum logic [2:0] {
        PhOffWait     = 3'd0,
        PhOnSettle    = 3'd1,
        PhOnRelease   = 3'd2,
        PhOnWait      = 3'd3,
        PhHoldSettle  = 3'd4,
        PhHold        = 3'd5
    } phase_t;

    typedef struct packed {
        logic supply;
        logic turbo;
        logic p_power;
        logic p_turbo;
    } result_t;

    // configuration
    logic               atx_mode_reg;
    logic               restore_en_reg;
    logic [HoldW-1:0]   powerdown_reg;
    logic [HoldW-1:0]   turbo_lim_reg;
    logic [SettleW-1:0] on_settle_reg;
    logic [SettleW-1:0] off_settle_reg;

    // control state
    phase_t             phase_reg, phase_next;
    logic               power_reg, power_next;
    logic               turbo_reg, turbo_next;
    logic [SettleW-1:0] settle_reg, settle_next;
    logic [HoldW-1:0]   hold_reg, hold_next;
    logic [HoldW-1:0]   hold_base;
    logic [HoldW-1:0]   hold_inc;
    logic               p_power;
    logic               p_turbo;

    // output register and skid entry
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    result_t res;

    logic item_fire;
    logic out_fire;

    assign item_fire = item_valid && !item_stall;
    assign out_fire  = out_valid_reg && !result_stall;

    assign item_stall   = skid_valid_reg;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign supply_on     = out_reg.supply;
    assign turbo_on      = out_reg.turbo;
    assign persist_power = out_reg.p_power;
    assign persist_turbo = out_reg.p_turbo;

    always_comb
    begin
        phase_next  = phase_reg;
        power_next  = power_reg;
        turbo_next  = turbo_reg;
        settle_next = settle_reg;
        hold_next   = hold_reg;
        p_power     = 1'b0;
        p_turbo     = 1'b0;
        hold_base   = (phase_reg == PhHoldSettle) ? '0 : hold_reg;
        hold_inc    = hold_base + HoldW'(1);
        if (hold_inc == HoldWrap)
        begin
            hold_inc = '0;
        end

        if (cmd)
        begin
            if (restore_en_reg)
            begin
                power_next  = saved_power;
                turbo_next  = saved_turbo;
                settle_next = '0;
                hold_next   = '0;
                phase_next  = saved_power ? PhOnWait : PhOffWait;
            end
        end
        else
        begin
            unique case (phase_reg)
                PhOnSettle:
                begin
                    if (settle_reg != '0)
                    begin
                        settle_next = settle_reg - SettleW'(1);
                    end
                    else
                    begin
                        phase_next = button_pressed ? PhOnRelease : PhOnWait;
                    end
                end
                PhOnRelease:
                begin
                    if (!button_pressed)
                    begin
                        phase_next = PhOnWait;
                    end
                end
                PhOnWait:
                begin
                    if (button_pressed)
                    begin
                        if (!atx_mode_reg)
                        begin
                            power_next = 1'b0;
                            p_power    = 1'b1;
                        end
                        settle_next = off_settle_reg;
                        hold_next   = '0;
                        phase_next  = PhHoldSettle;
                    end
                end
                PhHoldSettle, PhHold:
                begin
                    if (phase_reg == PhHoldSettle && settle_reg != '0)
                    begin
                        settle_next = settle_reg - SettleW'(1);
                    end
                    else
                    begin
                        phase_next = PhHold;
                        hold_next  = hold_base;
                        if (button_pressed)
                        begin
                            if (atx_mode_reg)
                            begin
                                hold_next = hold_inc;
                                if (hold_inc > powerdown_reg)
                                begin
                                    power_next = 1'b0;
                                    p_power    = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            // in ATX mode, a release strictly between the two limits flips turbo
                            if (atx_mode_reg && hold_base < powerdown_reg
                                && hold_base > turbo_lim_reg)
                            begin
                                turbo_next = !turbo_reg;
                                p_turbo    = 1'b1;
                            end
                            phase_next = power_reg ? PhOnWait : PhOffWait;
                        end
                    end
                end
                default:
                begin
                    phase_next = PhOffWait;
                    if (button_pressed)
                    begin
                        power_next  = 1'b1;
                        p_power     = 1'b1;
                        settle_next = on_settle_reg;
                        phase_next  = PhOnSettle;
                    end
                end
            endcase
        end

        res.supply  = power_next;
        res.turbo   = turbo_next;
        res.p_power = p_power;
        res.p_turbo = p_turbo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atx_mode_reg   <= RstAtxMode;
            restore_en_reg <= RstRestoreEnable;
            powerdown_reg  <= RstPowerdownTicks;
            turbo_lim_reg  <= RstTurboTicks;
            on_settle_reg  <= RstOnSettle;
            off_settle_reg <= RstOffSettle;
            phase_reg      <= PhOffWait;
            power_reg      <= 1'b0;
            turbo_reg      <= 1'b0;
            settle_reg     <= '0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CfgAtxMode:        atx_mode_reg   <= cfg_data[0];
                    CfgRestoreEnable:  restore_en_reg <= cfg_data[0];
                    CfgPowerdownTicks: powerdown_reg  <= cfg_data;
                    CfgTurboTicks:     turbo_lim_reg  <= cfg_data;
                    CfgOnSettleTicks:  on_settle_reg  <= cfg_data[SettleW-1:0];
                    CfgOffSettleTicks: off_settle_reg <= cfg_data[SettleW-1:0];
                    default:           ;
                endcase
            end

            if (item_fire)
            begin
                phase_reg  <= phase_next;
                power_reg  <= power_next;
                turbo_reg  <= turbo_next;
                settle_reg <= settle_next;
                hold_reg   <= hold_next;
            end

            // drain skid first, then load new results where there is room
            if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (item_fire)
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ sv/spsc_checker.sv @@
// ----------------------------------------------------------------------------
// spsc_checker
// Port-level checks of the soft power switch controller, bound to the core.
// ----------------------------------------------------------------------------
`include "soft_power_switch_controller_core_assert.svh"

module spsc_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall,
    input logic supply_on,
    input logic turbo_on,
    input logic cfg_valid,
    input logic cfg_ready
);

    // input stalls only when both output entries are taken
    `SPSC_ASSERT_IMPLY(a_stall_needs_result, clk, rst_n, item_stall, result_valid)

    // a transaction into an empty output shows up the next cycle
    `SPSC_ASSERT_NEXT(a_empty_loads, clk, rst_n,
        item_valid && !item_stall && !result_valid, result_valid)

    // configuration writes are never held off
    `SPSC_ASSERT_IMPLY(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

    // a stalled result holds its supply and turbo lines
    `SPSC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall,
        result_valid && $stable(supply_on) && $stable(turbo_on))

endmodule

bind soft_power_switch_controller_core spsc_checker u_spsc_checker (.*);
